// ===== hw/rtl/ptt_pkg.sv =====
`default_nettype none
package ptt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int TIME_BITS = 32;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [SLOT_W:0]      t_cnt;
    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [3:0]           t_slot_out;
    typedef logic [31:0]          t_word;

    localparam t_cnt SLOT_CNT = t_cnt'(NUM_SLOTS);

    typedef enum logic [2:0] {
        K_REGISTER = 3'd0,
        K_REMOVE   = 3'd1,
        K_PAUSE    = 3'd2,
        K_PLAY     = 3'd3,
        K_TICK     = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RESP  = 4'b0010,
        S_WALK  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    // memory access from the sequencer
    typedef struct packed {
        logic  re;
        t_slot raddr;
        logic  int_we;
        logic  last_we;
        t_slot waddr;
        t_time int_wdata;
        t_time last_wdata;
    } t_mem_cmd;

    // one result handed to the output register
    typedef struct packed {
        logic      valid;
        t_slot_out slot;
        t_word     elapsed;
        logic      fired;
        logic      status;
        logic      last;
    } t_push;

endpackage
`default_nettype wire

// ===== hw/rtl/ptt_if.sv =====
`default_nettype none
interface ptt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  task_id;
    logic [31:0] interval_ticks;
    logic [31:0] now_ticks;

    modport source (output valid, kind, task_id, interval_ticks, now_ticks, input ready);
    modport sink   (input valid, kind, task_id, interval_ticks, now_ticks, output ready);
endinterface

interface ptt_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  slot;
    logic [31:0] elapsed_ticks;
    logic        fired;
    logic        status;
    logic        last_of_run;

    modport source (output valid, slot, elapsed_ticks, fired, status, last_of_run, input ready);
    modport sink   (input valid, slot, elapsed_ticks, fired, status, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ptt_ram.sv =====
`default_nettype none
module ptt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic                                         i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while i_re is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ptt_ctrl.sv =====
`default_nettype none
module ptt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    ptt_req_if.sink            i_req,
    input  wire logic          i_out_free,
    input  wire ptt_pkg::t_time i_int_rdata,
    input  wire ptt_pkg::t_time i_last_rdata,
    output ptt_pkg::t_mem_cmd  o_mem,
    output ptt_pkg::t_push     o_push
);

    ptt_pkg::t_state              r_state, n_state;
    logic [ptt_pkg::NUM_SLOTS-1:0] r_used;
    logic [ptt_pkg::NUM_SLOTS-1:0] r_paused;
    ptt_pkg::t_slot_out           r_rsp_slot;
    logic                         r_rsp_status;
    ptt_pkg::t_time               r_now;
    ptt_pkg::t_cnt                r_idx;
    logic                         r_ev_valid;
    ptt_pkg::t_slot               r_ev_idx;
    logic                         r_ev_paused;
    logic                         r_pend_valid;
    ptt_pkg::t_slot               r_pend_slot;
    ptt_pkg::t_time               r_pend_elapsed;

    logic           req_fire;
    logic           id_ok;
    ptt_pkg::t_slot id;
    logic           in_use;
    logic           in_walk;
    logic           issuing;
    ptt_pkg::t_slot iw;
    ptt_pkg::t_time elapsed;
    logic           fire;
    logic           stall;
    logic           step;

    assign i_req.ready = (r_state == ptt_pkg::S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign id_ok       = 32'(i_req.task_id) < 32'(ptt_pkg::NUM_SLOTS);
    assign id          = ptt_pkg::t_slot'(i_req.task_id);
    assign in_use      = id_ok && r_used[id];

    assign in_walk = (r_state == ptt_pkg::S_WALK);
    assign issuing = r_idx < ptt_pkg::SLOT_CNT;
    assign iw      = r_idx[ptt_pkg::SLOT_W-1:0];

    // evaluate stage: RAM data for r_ev_idx arrives this cycle
    assign elapsed = r_now - i_last_rdata;
    assign fire    = r_ev_valid && !r_ev_paused && (elapsed >= i_int_rdata);
    // a new fire pushes the held one out, so it needs the output free
    assign stall   = fire && r_pend_valid && !i_out_free;
    assign step    = in_walk && !stall;

    always_comb begin
        o_mem.re         = step && issuing;
        o_mem.raddr      = iw;
        o_mem.int_we     = req_fire && (i_req.kind == ptt_pkg::K_REGISTER) && id_ok;
        o_mem.last_we    = o_mem.int_we || (step && r_ev_valid && (r_ev_paused || fire));
        o_mem.waddr      = in_walk ? r_ev_idx : id;
        o_mem.int_wdata  = ptt_pkg::t_time'(i_req.interval_ticks);
        o_mem.last_wdata = in_walk ? r_now : ptt_pkg::t_time'(i_req.now_ticks);
    end

    always_comb begin
        o_push         = '0;
        o_push.slot    = ptt_pkg::t_slot_out'(r_pend_slot);
        o_push.elapsed = ptt_pkg::t_word'(r_pend_elapsed);
        o_push.fired   = 1'b1;
        case (r_state)
            ptt_pkg::S_RESP: begin
                o_push.valid   = i_out_free;
                o_push.slot    = r_rsp_slot;
                o_push.elapsed = '0;
                o_push.fired   = 1'b0;
                o_push.status  = r_rsp_status;
                o_push.last    = 1'b1;
            end
            ptt_pkg::S_WALK: begin
                o_push.valid = fire && r_pend_valid && i_out_free;
            end
            ptt_pkg::S_FLUSH: begin
                o_push.valid = r_pend_valid && i_out_free;
                o_push.last  = 1'b1;
            end
            default: begin
                o_push.valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ptt_pkg::S_IDLE: begin
                if (req_fire) begin
                    case (i_req.kind)
                        ptt_pkg::K_REGISTER, ptt_pkg::K_REMOVE,
                        ptt_pkg::K_PAUSE, ptt_pkg::K_PLAY: n_state = ptt_pkg::S_RESP;
                        ptt_pkg::K_TICK:                   n_state = ptt_pkg::S_WALK;
                        default:                           n_state = ptt_pkg::S_IDLE;
                    endcase
                end
            end
            ptt_pkg::S_RESP: begin
                if (i_out_free) begin
                    n_state = ptt_pkg::S_IDLE;
                end
            end
            ptt_pkg::S_WALK: begin
                if (step && !issuing) begin
                    n_state = ptt_pkg::S_FLUSH;
                end
            end
            ptt_pkg::S_FLUSH: begin
                if (!r_pend_valid || i_out_free) begin
                    n_state = ptt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ptt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptt_pkg::S_IDLE;
            r_used       <= '0;
            r_paused     <= '0;
            r_ev_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (req_fire) begin
                case (i_req.kind)
                    ptt_pkg::K_REGISTER: begin
                        if (id_ok) begin
                            r_used[id]   <= 1'b1;
                            r_paused[id] <= 1'b0;
                        end
                    end
                    ptt_pkg::K_REMOVE: begin
                        if (in_use) begin
                            r_used[id]   <= 1'b0;
                            r_paused[id] <= 1'b0;
                        end
                    end
                    ptt_pkg::K_PAUSE, ptt_pkg::K_PLAY: begin
                        if (in_use) begin
                            r_paused[id] <= (i_req.kind == ptt_pkg::K_PAUSE);
                        end
                    end
                    ptt_pkg::K_TICK: begin
                        r_ev_valid   <= 1'b0;
                        r_pend_valid <= 1'b0;
                    end
                    default: begin
                        r_ev_valid <= 1'b0;
                    end
                endcase
            end
            if (step) begin
                r_ev_valid <= issuing && r_used[iw];
                if (fire) begin
                    r_pend_valid <= 1'b1;
                end
            end
            if ((r_state == ptt_pkg::S_FLUSH) && (!r_pend_valid || i_out_free)) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_rsp_slot   <= i_req.task_id;
            r_rsp_status <= (i_req.kind == ptt_pkg::K_REGISTER) ? !id_ok : !in_use;
            r_now        <= ptt_pkg::t_time'(i_req.now_ticks);
            r_idx        <= '0;
        end
        if (step) begin
            r_ev_idx    <= iw;
            r_ev_paused <= r_paused[iw];
            r_idx       <= r_idx + ptt_pkg::t_cnt'(issuing);
            if (fire) begin
                r_pend_slot    <= r_ev_idx;
                r_pend_elapsed <= elapsed;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/periodic_task_timer_table.sv =====
// Periodic task timer table with 16 slots. Each request is one of register, remove, pause,
// play or tick. Register, remove, pause and play give one result each, which passes through
// the S_RESP state into the output register once that is free. A tick reads one slot per
// cycle, while the output is not held back, from the interval and last-time RAMs (both read
// at the same address); it gives one result per firing slot in ascending order, marks the
// final one with last_of_run, and gives no result when nothing fires. The last fire of a tick
// is held until the walk ends, so results lag the walk by one firing. Requests of an unknown
// kind are taken and dropped. The next request is taken as soon as the previous one is
// finished, while its last result may still wait in the output register. No clearing pass
// is needed after reset.
`default_nettype none
module periodic_task_timer_table (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ptt_req_if.sink   i_req,
    ptt_rsp_if.source o_rsp
);

    ptt_pkg::t_mem_cmd mem;
    ptt_pkg::t_push    push;
    ptt_pkg::t_time    int_rdata;
    ptt_pkg::t_time    last_rdata;
    logic              out_free;

    logic               r_out_valid;
    ptt_pkg::t_slot_out r_out_slot;
    ptt_pkg::t_word     r_out_elapsed;
    logic               r_out_fired;
    logic               r_out_status;
    logic               r_out_last;

    assign out_free = !r_out_valid || o_rsp.ready;

    ptt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_out_free   (out_free),
        .i_int_rdata  (int_rdata),
        .i_last_rdata (last_rdata),
        .o_mem        (mem),
        .o_push       (push)
    );

    ptt_ram #(
        .DEPTH (ptt_pkg::NUM_SLOTS),
        .WIDTH (ptt_pkg::TIME_BITS)
    ) u_int_ram (
        .i_clk   (i_clk),
        .i_we    (mem.int_we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.int_wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (int_rdata)
    );

    ptt_ram #(
        .DEPTH (ptt_pkg::NUM_SLOTS),
        .WIDTH (ptt_pkg::TIME_BITS)
    ) u_last_ram (
        .i_clk   (i_clk),
        .i_we    (mem.last_we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.last_wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (last_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push.valid) begin
            r_out_slot    <= push.slot;
            r_out_elapsed <= push.elapsed;
            r_out_fired   <= push.fired;
            r_out_status  <= push.status;
            r_out_last    <= push.last;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.slot          = r_out_slot;
    assign o_rsp.elapsed_ticks = r_out_elapsed;
    assign o_rsp.fired         = r_out_fired;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.last_of_run   = r_out_last;

    // a result is never loaded over one that is still waiting
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> out_free)
        else $error("result pushed into an occupied output register");

    // single-slot requests always end their own run
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.fired |-> o_rsp.last_of_run)
        else $error("single-slot result without last_of_run");

    // a fire reports no error status
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.fired |-> !o_rsp.status)
        else $error("fire result with error status");

    // a tick request occupies the sequencer for its walk
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && (i_req.kind == ptt_pkg::K_TICK) |=> !i_req.ready)
        else $error("request taken during a tick walk");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
    import ptt_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 320;
    localparam int MAX_REPORTS  = 40;
    localparam logic [2:0] KIND_BAD_LO = 3'd5;
    localparam logic [2:0] KIND_BAD_HI = 3'd7;

    typedef struct {
        logic [2:0] kind;
        logic [3:0] task_id;
        t_time      interval;
        t_time      now;
        bit         drain;   // hold back until every result due has come
    } timer_cmd_t;

    typedef struct {
        t_slot_out slot;
        t_word     elapsed;
        logic      fired;
        logic      status;
        logic      last;
    } timer_event_t;

    logic i_clk;
    logic i_rst_n;

    ptt_req_if req_ch ();
    ptt_rsp_if rsp_ch ();

    periodic_task_timer_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // shadow copy of the timer table
    bit    tab_used     [NUM_SLOTS];
    bit    tab_paused   [NUM_SLOTS];
    t_time tab_interval [NUM_SLOTS];
    t_time tab_last     [NUM_SLOTS];

    timer_cmd_t   cmd_backlog[$];
    timer_event_t timer_events_due[$];
    timer_cmd_t   cur_cmd;
    timer_event_t want;

    int n_total;
    int n_sent;
    int n_checked;
    int n_fires;
    int n_not_in_use;
    int n_err;
    int cyc_cnt;
    int burst_left;
    int gap_left;
    int stall_left;
    int rsp_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic push_cmd(input logic [2:0] kind, input logic [3:0] id,
                            input t_time interval, input t_time now, input bit drain);
        timer_cmd_t c;
        c.kind     = kind;
        c.task_id  = id;
        c.interval = interval;
        c.now      = now;
        c.drain    = drain;
        cmd_backlog.push_back(c);
    endtask

    // apply one request to the shadow table and queue the results it causes
    task automatic model_timer_table(input timer_cmd_t c);
        timer_event_t e;
        timer_event_t run[$];
        t_time        el;
        int           s;
        e.slot    = c.task_id;
        e.elapsed = '0;
        e.fired   = 1'b0;
        e.status  = 1'b0;
        e.last    = 1'b1;
        case (c.kind)
            K_REGISTER: begin
                tab_used[c.task_id]     = 1'b1;
                tab_paused[c.task_id]   = 1'b0;
                tab_interval[c.task_id] = c.interval;
                tab_last[c.task_id]     = c.now;
                timer_events_due.push_back(e);
            end
            K_REMOVE, K_PAUSE, K_PLAY: begin
                if (tab_used[c.task_id]) begin
                    if (c.kind == K_REMOVE) begin
                        tab_used[c.task_id]   = 1'b0;
                        tab_paused[c.task_id] = 1'b0;
                    end else begin
                        tab_paused[c.task_id] = (c.kind == K_PAUSE);
                    end
                end else begin
                    e.status = 1'b1;
                end
                timer_events_due.push_back(e);
            end
            K_TICK: begin
                for (s = 0; s < NUM_SLOTS; s++) begin
                    if (tab_used[s]) begin
                        if (tab_paused[s]) begin
                            tab_last[s] = c.now;
                        end else begin
                            el = c.now - tab_last[s];
                            if (el >= tab_interval[s]) begin
                                tab_last[s] = c.now;
                                e.slot    = t_slot_out'(s);
                                e.elapsed = t_word'(el);
                                e.fired   = 1'b1;
                                e.last    = 1'b0;
                                run.push_back(e);
                            end
                        end
                    end
                end
                if (run.size() != 0)
                    run[run.size()-1].last = 1'b1;
                foreach (run[i])
                    timer_events_due.push_back(run[i]);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            n_err++;
            if (n_err <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
        end
    endtask

    // request driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                model_timer_table(cur_cmd);
                n_sent++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else if (cmd_backlog.size() != 0 &&
                             !(cmd_backlog[0].drain && timer_events_due.size() != 0)) begin
                    cur_cmd = cmd_backlog.pop_front();
                    req_ch.valid          <= 1'b1;
                    req_ch.kind           <= cur_cmd.kind;
                    req_ch.task_id        <= cur_cmd.task_id;
                    req_ch.interval_ticks <= cur_cmd.interval;
                    req_ch.now_ticks      <= cur_cmd.now;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            rsp_cycles++;
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (timer_events_due.size() == 0) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual slot %0h",
                                 $time, rsp_ch.slot);
                end else begin
                    want = timer_events_due.pop_front();
                    check_field("slot", want.slot, rsp_ch.slot);
                    check_field("elapsed_ticks", want.elapsed, rsp_ch.elapsed_ticks);
                    check_field("fired", want.fired, rsp_ch.fired);
                    check_field("status", want.status, rsp_ch.status);
                    check_field("last_of_run", want.last, rsp_ch.last_of_run);
                    n_checked++;
                    if (want.fired)
                        n_fires++;
                    if (want.status)
                        n_not_in_use++;
                end
            end
            // alternate windows: free-flowing, then stalls of random length
            if (stall_left != 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (rsp_cycles[8] && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 10);
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results still due", $time, timer_events_due.size());
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        t_time t_now;
        int    n_rand;
        int    pick;
        int    k;
        int    s;
        bit    full_done;

        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.kind           = '0;
        req_ch.task_id        = '0;
        req_ch.interval_ticks = '0;
        req_ch.now_ticks      = '0;
        rsp_ch.ready          = 1'b0;
        n_sent = 0;
        n_checked = 0;
        n_fires = 0;
        n_not_in_use = 0;
        n_err = 0;
        cyc_cnt = 0;
        burst_left = 0;
        gap_left = 0;
        stall_left = 0;
        rsp_cycles = 0;
        foreach (tab_used[i]) begin
            tab_used[i]   = 1'b0;
            tab_paused[i] = 1'b0;
        end

        // directed: unused slots, empty tick, extremes, pause/play, wrap
        push_cmd(K_REMOVE, 4'd0, '0, '0, 1'b0);
        push_cmd(K_PAUSE, 4'd5, '1, '1, 1'b0);
        push_cmd(K_PLAY, 4'd15, '0, '1, 1'b0);
        push_cmd(K_TICK, 4'd0, '0, 32'd50, 1'b0);
        push_cmd(K_REGISTER, 4'd0, '0, '0, 1'b0);
        push_cmd(K_REGISTER, 4'd15, '1, '1, 1'b0);
        push_cmd(K_REGISTER, 4'd7, 32'd10, 32'd100, 1'b0);
        push_cmd(K_TICK, 4'd15, '1, 32'd105, 1'b0);
        push_cmd(K_PAUSE, 4'd0, '0, '0, 1'b0);
        push_cmd(K_TICK, 4'd3, '0, 32'd200, 1'b0);
        push_cmd(K_PLAY, 4'd0, '0, '0, 1'b0);
        push_cmd(K_TICK, 4'd0, '0, 32'd200, 1'b0);
        push_cmd(K_PAUSE, 4'd7, '0, '0, 1'b0);
        push_cmd(K_REGISTER, 4'd7, 32'd3, 32'd200, 1'b0);   // overwrite clears pause
        push_cmd(K_REGISTER, 4'd3, 32'd5, 32'hFFFF_FFFE, 1'b0);
        push_cmd(K_TICK, 4'd0, '0, 32'd3, 1'b0);             // elapsed wraps
        push_cmd(K_TICK, 4'd0, '0, 32'hFFFF_FFFE, 1'b0);     // full-scale interval met
        for (k = KIND_BAD_LO; k <= KIND_BAD_HI; k++)
            push_cmd(3'(k), '1, '1, '1, 1'b0);
        push_cmd(K_REMOVE, 4'd0, '1, '1, 1'b0);
        push_cmd(K_REMOVE, 4'd0, '0, '0, 1'b0);
        push_cmd(K_PLAY, 4'd3, '0, '0, 1'b0);
        push_cmd(K_REGISTER, 4'd9, '1, '0, 1'b0);
        push_cmd(K_TICK, 4'd9, '1, '1, 1'b0);

        // random: mostly ordered time with small intervals, some noise
        t_now = 32'hFFFF_F000;
        n_rand = 0;
        full_done = 1'b0;
        while (n_rand < RANDOM_ITEMS) begin
            if (!full_done && n_rand >= RANDOM_ITEMS / 2) begin
                // whole table fires on one tick, after the pipeline drains
                full_done = 1'b1;
                for (s = 0; s < NUM_SLOTS; s++)
                    push_cmd(K_REGISTER, 4'(s), '0, t_now, s == 0);
                t_now += 1;
                push_cmd(K_TICK, 4'($urandom), $urandom, t_now, 1'b0);
                n_rand += NUM_SLOTS + 1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                k = $urandom_range(2, 6);
                repeat (k)
                    push_cmd(K_REGISTER, 4'($urandom), $urandom_range(0, 60), t_now, 1'b0);
                n_rand += k;
                repeat ($urandom_range(1, 3)) begin
                    t_now += $urandom_range(0, 60);
                    push_cmd(K_TICK, 4'($urandom), $urandom, t_now, 1'b0);
                    n_rand++;
                end
            end else if (pick < 50) begin
                k = $urandom_range(0, 99);
                if (k < 80)
                    t_now += $urandom_range(0, 60);
                else if (k < 95)
                    t_now += $urandom_range(0, 100000);
                else
                    t_now = $urandom;
                push_cmd(K_TICK, 4'($urandom), $urandom, t_now, 1'b0);
                n_rand++;
            end else if (pick < 68) begin
                k = $urandom_range(0, 99);
                push_cmd(K_REGISTER, 4'($urandom),
                         (k < 60) ? t_time'($urandom_range(0, 80)) :
                         (k < 75) ? t_time'(0) :
                         (k < 90) ? t_time'($urandom_range(0, 5000)) : t_time'($urandom),
                         ($urandom_range(0, 99) < 85) ? t_now : t_time'($urandom), 1'b0);
                n_rand++;
            end else if (pick < 96) begin
                push_cmd((pick < 78) ? K_REMOVE : (pick < 87) ? K_PAUSE : K_PLAY,
                         4'($urandom), $urandom, $urandom, 1'b0);
                n_rand++;
            end else begin
                push_cmd(3'($urandom_range(KIND_BAD_LO, KIND_BAD_HI)), 4'($urandom),
                         $urandom, $urandom, 1'b0);
                n_rand++;
            end
        end
        n_total = cmd_backlog.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != n_total || timer_events_due.size() != 0)
            @(posedge i_clk);
        // a last tick may still be walking with nothing to report
        repeat (4 * NUM_SLOTS) @(posedge i_clk);

        $display("summary: %0d requests of all kinds incl. unknown ones, wrapping times",
                 n_sent);
        $display("summary: %0d results checked, %0d fires, %0d on slots not in use",
                 n_checked, n_fires, n_not_in_use);
        if (n_err == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
`default_nettype wire
